[rtl/core/bct_pkg.sv]
package bct_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned CountW = 7;
  localparam int unsigned TW     = 17;  // Q0.16 with 1.0 representable
  localparam int unsigned SqW    = 2 * TW;
  localparam int unsigned CubeW  = 3 * TW;
  localparam int unsigned WgtW   = 33;  // Q0.32 weight, 1.0 included
  localparam int unsigned ProdW  = WgtW + 1 + CoordW;
  localparam int unsigned SumW   = ProdW + 2;
  localparam int unsigned DivBitW = 5;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x0, y0, x1, y1, x2, y2, x3, y3;
  } curve_pts_t;

  typedef struct packed {
    logic         valid;
    logic         cubic;
    logic         last;
    logic [TW-1:0] t;
    curve_pts_t   pts;
  } issue_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_RUN
  } seq_state_e;

endpackage

[rtl/core/bct_if.sv]
interface bct_in_if;
  logic                         valid;
  logic                         ready;
  logic                         is_cubic;
  logic [bct_pkg::CountW-1:0]   segment_count;
  logic signed [bct_pkg::CoordW-1:0] point0_x, point0_y, point1_x, point1_y;
  logic signed [bct_pkg::CoordW-1:0] point2_x, point2_y, point3_x, point3_y;

  modport source (output valid, is_cubic, segment_count, point0_x, point0_y,
                  point1_x, point1_y, point2_x, point2_y, point3_x, point3_y,
                  input ready);
  modport sink (input valid, is_cubic, segment_count, point0_x, point0_y,
                point1_x, point1_y, point2_x, point2_y, point3_x, point3_y,
                output ready);
endinterface

interface bct_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bct_pkg::CoordW-1:0] curve_x;
  logic signed [bct_pkg::CoordW-1:0] curve_y;
  logic                              last_point;

  modport source (output valid, curve_x, curve_y, last_point, input ready);
  modport sink (input valid, curve_x, curve_y, last_point, output ready);
endinterface

[rtl/core/bct_seq.sv]
module bct_seq #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bct_in_if.sink          in_i,
  input  logic            adv_i,
  output bct_pkg::issue_t issue_o
);
  import bct_pkg::*;

  seq_state_e state_q, state_d;
  logic [CountW-1:0]  n_q, n_d, i_q, i_d, r_q, r_d, q_rem_q, q_rem_d;
  logic [TW-1:0]      t_q, t_d, q_q, q_d;
  logic [DivBitW-1:0] bit_q, bit_d;
  logic               cubic_q, cubic_d;
  curve_pts_t         pts_q, pts_d;
  logic [CountW-1:0]  n_sat;
  logic [CountW:0]    trial, rsum;

  assign n_sat = (in_i.segment_count > CountW'(MAX_SEGMENTS)) ?
                 CountW'(MAX_SEGMENTS) : in_i.segment_count;
  assign in_i.ready = (state_q == SEQ_IDLE);

  // restoring division of 2^16 by n, one quotient bit per cycle
  assign trial = {q_rem_q, (bit_q == DivBitW'(TW - 1))};
  assign rsum  = {1'b0, r_q} + {1'b0, q_rem_q};

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    i_d     = i_q;
    r_d     = r_q;
    q_rem_d = q_rem_q;
    t_d     = t_q;
    q_d     = q_q;
    bit_d   = bit_q;
    cubic_d = cubic_q;
    pts_d   = pts_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (in_i.valid && n_sat != '0) begin
          state_d = SEQ_DIV;
          n_d     = n_sat;
          cubic_d = in_i.is_cubic;
          pts_d   = '{in_i.point0_x, in_i.point0_y, in_i.point1_x, in_i.point1_y,
                      in_i.point2_x, in_i.point2_y, in_i.point3_x, in_i.point3_y};
          q_rem_d = '0;
          q_d     = '0;
          bit_d   = DivBitW'(TW - 1);
        end
      end
      SEQ_DIV: begin
        if (trial >= {1'b0, n_q}) begin
          q_rem_d = CountW'(trial - {1'b0, n_q});
          q_d     = {q_q[TW-2:0], 1'b1};
        end else begin
          q_rem_d = trial[CountW-1:0];
          q_d     = {q_q[TW-2:0], 1'b0};
        end
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          state_d = SEQ_RUN;
          i_d     = CountW'(1);
          t_d     = q_d;
          r_d     = q_rem_d;
        end
      end
      SEQ_RUN: begin
        if (adv_i) begin
          i_d = i_q + 1'b1;
          if (rsum >= {1'b0, n_q}) begin
            r_d = CountW'(rsum - {1'b0, n_q});
            t_d = t_q + q_q + 1'b1;
          end else begin
            r_d = rsum[CountW-1:0];
            t_d = t_q + q_q;
          end
          if (i_q == n_q) state_d = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    i_q     <= i_d;
    r_q     <= r_d;
    q_rem_q <= q_rem_d;
    t_q     <= t_d;
    q_q     <= q_d;
    bit_q   <= bit_d;
    cubic_q <= cubic_d;
    pts_q   <= pts_d;
  end

  assign issue_o.valid = (state_q == SEQ_RUN);
  assign issue_o.cubic = cubic_q;
  assign issue_o.last  = (i_q == n_q);
  assign issue_o.t     = t_q;
  assign issue_o.pts   = pts_q;

endmodule

[rtl/core/bct_pipe.sv]
module bct_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bct_pkg::issue_t issue_i,
  output logic            adv_o,
  bct_out_if.source       out_o
);
  import bct_pkg::*;

  localparam logic [TW-1:0] TOne = TW'(1) << (TW - 1);

  // stage 1: u, t and their squares
  logic           v1_q, v2_q, v3_q, vo_q;
  logic           c1_q;
  logic           l1_q, l2_q, l3_q, lo_q;
  curve_pts_t     p1_q, p2_q;
  logic [TW-1:0]  t1_q, u1_q, u1;
  logic [SqW-1:0] uu1_q, ut1_q, tt1_q;

  // stage 2: Bernstein weights
  logic [WgtW-1:0] w0_q, w1_q, w2_q, w3_q, w0, w1, w2, w3;
  logic [CubeW-1:0]   uuu, uut, utt, ttt;
  logic [CubeW+1:0]   uut3, utt3;

  // stage 3: weighted coordinates
  logic signed [ProdW-1:0] px_q [4];
  logic signed [ProdW-1:0] py_q [4];

  // output
  coord_t ox_q, oy_q;
  logic signed [SumW-1:0] sx, sy;

  assign adv_o = !vo_q || out_o.ready;
  assign u1    = TOne - issue_i.t;

  assign uuu  = uu1_q * u1_q;
  assign uut  = uu1_q * t1_q;
  assign utt  = tt1_q * u1_q;
  assign ttt  = tt1_q * t1_q;
  assign uut3 = {2'b0, uut} + {1'b0, uut, 1'b0};
  assign utt3 = {2'b0, utt} + {1'b0, utt, 1'b0};

  always_comb begin
    if (c1_q) begin
      w0 = WgtW'((uuu  + (CubeW)'(1 << 15)) >> 16);
      w1 = WgtW'((uut3 + (CubeW+2)'(1 << 15)) >> 16);
      w2 = WgtW'((utt3 + (CubeW+2)'(1 << 15)) >> 16);
      w3 = WgtW'((ttt  + (CubeW)'(1 << 15)) >> 16);
    end else begin
      w0 = WgtW'(uu1_q);
      w1 = WgtW'({ut1_q, 1'b0});
      w2 = WgtW'(tt1_q);
      w3 = '0;
    end
  end

  function automatic coord_t finish(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] r;
    r = (s + SumW'(64'sd1 << 31)) >>> 32;
    if (r > SumW'(8388607))       finish = coord_t'(24'sh7FFFFF);
    else if (r < -SumW'(8388608)) finish = coord_t'(24'sh800000);
    else                          finish = r[CoordW-1:0];
  endfunction

  assign sx = SumW'(px_q[0]) + SumW'(px_q[1]) + SumW'(px_q[2]) + SumW'(px_q[3]);
  assign sy = SumW'(py_q[0]) + SumW'(py_q[1]) + SumW'(py_q[2]) + SumW'(py_q[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv_o) begin
      v1_q <= issue_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      c1_q  <= issue_i.cubic;
      l1_q  <= issue_i.last;
      p1_q  <= issue_i.pts;
      t1_q  <= issue_i.t;
      u1_q  <= u1;
      uu1_q <= u1 * u1;
      ut1_q <= u1 * issue_i.t;
      tt1_q <= issue_i.t * issue_i.t;

      l2_q <= l1_q;
      p2_q <= p1_q;
      w0_q <= w0;
      w1_q <= w1;
      w2_q <= w2;
      w3_q <= w3;

      // w3 is zero for a quadratic curve, so point 3 drops out
      l3_q     <= l2_q;
      px_q[0]  <= $signed({1'b0, w0_q}) * p2_q.x0;
      px_q[1]  <= $signed({1'b0, w1_q}) * p2_q.x1;
      px_q[2]  <= $signed({1'b0, w2_q}) * p2_q.x2;
      px_q[3]  <= $signed({1'b0, w3_q}) * p2_q.x3;
      py_q[0]  <= $signed({1'b0, w0_q}) * p2_q.y0;
      py_q[1]  <= $signed({1'b0, w1_q}) * p2_q.y1;
      py_q[2]  <= $signed({1'b0, w2_q}) * p2_q.y2;
      py_q[3]  <= $signed({1'b0, w3_q}) * p2_q.y3;

      lo_q <= l3_q;
      ox_q <= finish(sx);
      oy_q <= finish(sy);
    end
  end

  assign out_o.valid      = vo_q;
  assign out_o.curve_x    = ox_q;
  assign out_o.curve_y    = oy_q;
  assign out_o.last_point = lo_q;

endmodule

[rtl/core/bezier_curve_tessellator.sv]
// Uniform Bezier tessellator: takes one quadratic or cubic curve per input
// beat and emits segment_count points (t = i/n, i = 1..n, start point not
// emitted), saturated to MAX_SEGMENTS. A curve occupies the input through its
// acceptance, the bit-serial reciprocal 2^16/n, then one point issued per
// cycle while the datapath is not stalled, into a four-register datapath
// (squares, weights, weighted coordinates, sum/round/saturate into the output
// register). Output backpressure stalls the whole datapath. A zero count is
// accepted with no output and leaves the input ready.
module bezier_curve_tessellator #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  bct_in_if.sink    in_i,
  bct_out_if.source out_o
);
  import bct_pkg::*;

  issue_t issue;
  logic   adv;

  bct_seq #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .issue_o (issue)
  );

  bct_pipe u_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .adv_o   (adv),
    .out_o   (out_o)
  );

endmodule
